// File: hw/rtl/ovl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_pkg
// Shared codes and types for the ordered value list and its cells.
// ----------------------------------------------------------------------------
package ovl_pkg;

  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int OCOUNT_W = 6;
  localparam int ACTION_W = 2;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ENTRY     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic append;   // write key into the cell at the tail position
    logic remove;   // close the gap behind the first match
    logic rotate;   // move every entry one toward the head, head to tail
  } cell_ctl_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_DUMP = 2'b10
  } fsm_t;

endpackage

// File: hw/rtl/ovl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_cell
// One list slot: holds a value, compares it with the key, takes the key on
// append and takes its neighbor's value on remove and dump rotation.
// ----------------------------------------------------------------------------
module ovl_cell #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic                             clk,
  input  ovl_pkg::cell_ctl_t               ctl,
  input  logic [CW-1:0]                    cnt,
  input  logic signed [ovl_pkg::VAL_W-1:0] key,
  input  logic signed [ovl_pkg::VAL_W-1:0] next_val,
  input  logic signed [ovl_pkg::VAL_W-1:0] head_val,
  input  logic                             hit_in,
  output logic                             hit_out,
  output logic signed [ovl_pkg::VAL_W-1:0] val
);
  import ovl_pkg::*;

  localparam logic [CW-1:0] IDX_V = CW'(IDX);

  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    occ, match, at_tail, is_last;

  assign occ     = IDX_V < cnt;
  assign match   = occ && (val_r == key);
  assign hit_out = hit_in | match;
  assign at_tail = IDX_V == cnt;
  assign is_last = (IDX_V + CW'(1)) == cnt;
  assign val     = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.append && at_tail) begin
      val_nxt = key;
    end else if (ctl.remove && hit_out) begin
      val_nxt = next_val;
    end else if (ctl.rotate) begin
      val_nxt = is_last ? head_val : next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: hw/rtl/ordered_value_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list
// Bounded ordered list of signed 32-bit values with append, remove by value
// and dump.
// ----------------------------------------------------------------------------
// The list lives in a row of LIST_DEPTH cells. Append and remove each give
// one result: every cell compares against the value at once, and the first
// match and the cells behind it take their neighbor's value in the same
// cycle. A dump of n entries first starts, then gives one entry per cycle
// while no result waits on out_stall, as the row rotates its head out and
// back to the tail, which leaves the order intact. Dumping an empty list
// gives a single empty result. No new request is taken while a dump runs
// or while a result waits on out_stall. The store needs no clearing after
// reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_value_list #(
  parameter int LIST_DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ovl_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [ovl_pkg::VAL_W-1:0]    in_item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ovl_pkg::STATUS_W-1:0]        out_status,
  output logic signed [ovl_pkg::VAL_W-1:0]    out_entry_value,
  output logic [ovl_pkg::OCOUNT_W-1:0]        out_entry_count,
  output logic                                out_last_result
);
  import ovl_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_V = CW'(LIST_DEPTH);

  fsm_t                    state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_val_r, out_val_nxt;
  logic [OCOUNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                    out_last_r, out_last_nxt;

  cell_ctl_t               ctl;
  logic                    accept, out_hold, full, found, dump_last;
  logic                    hit [LIST_DEPTH+1];
  logic signed [VAL_W-1:0] vals [LIST_DEPTH];

  assign out_hold  = out_valid_r && out_stall;
  assign in_stall  = (state_r != FSM_IDLE) || out_hold;
  assign accept    = in_valid && !in_stall;
  assign full      = cnt_r >= DEPTH_V;
  assign found     = hit[LIST_DEPTH];
  assign dump_last = (idx_r + CW'(1)) == cnt_r;

  assign ctl.append = accept && (in_action == ACT_APPEND) && !full;
  assign ctl.remove = accept && (in_action == ACT_REMOVE);
  assign ctl.rotate = (state_r == FSM_DUMP) && !out_hold;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] nb;
    if (i + 1 < LIST_DEPTH) begin : g_mid
      assign nb = vals[i+1];
    end else begin : g_end
      assign nb = '0;
    end
    ovl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cnt      (cnt_r),
      .key      (in_item_value),
      .next_val (nb),
      .head_val (vals[0]),
      .hit_in   (hit[i]),
      .hit_out  (hit[i+1]),
      .val      (vals[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_val_nxt    = out_val_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          out_val_nxt  = '0;
          out_last_nxt = 1'b1;
          case (in_action)
            ACT_APPEND: begin
              if (!full) begin
                cnt_nxt = cnt_r + CW'(1);
              end
              out_valid_nxt  = 1'b1;
              out_status_nxt = full ? ST_FULL : ST_APPENDED;
              out_cnt_nxt    = OCOUNT_W'(cnt_nxt);
            end
            ACT_REMOVE: begin
              if (found) begin
                cnt_nxt = cnt_r - CW'(1);
              end
              out_valid_nxt  = 1'b1;
              out_status_nxt = found ? ST_REMOVED : ST_NOT_FOUND;
              out_cnt_nxt    = OCOUNT_W'(cnt_nxt);
            end
            ACT_DUMP: begin
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
                out_cnt_nxt    = '0;
              end else begin
                // start rotating entries out from the next cycle
                state_nxt = FSM_DUMP;
                idx_nxt   = '0;
              end
            end
            default: begin
              // unused action: drop the request
            end
          endcase
        end
      end
      FSM_DUMP: begin
        if (!out_hold) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ENTRY;
          out_val_nxt    = vals[0];
          out_cnt_nxt    = OCOUNT_W'(cnt_r);
          out_last_nxt   = dump_last;
          idx_nxt        = idx_r + CW'(1);
          if (dump_last) begin
            state_nxt = FSM_IDLE;
          end
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_val_r    <= out_val_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_val_r;
  assign out_entry_count = out_cnt_r;
  assign out_last_result = out_last_r;

endmodule
